// ===== hdl/lwpw_pkg.sv =====
// Shared types and constants of the window pixel writer.
package lwpw_pkg;

  localparam int BYTE_W   = 8;
  localparam int ORIG_W   = 10;
  localparam int DIM_W    = 11;
  localparam int END_W    = 12;
  localparam int PIX_W    = 16;
  localparam int PROD_W   = 2 * DIM_W;
  localparam int LEFT_W   = 21;
  localparam int QDEPTH   = 2;
  localparam int MAX_DIM_DEF = 1024;

  localparam logic [LEFT_W-1:0] LEFT_MAX = {LEFT_W{1'b1}};

  localparam logic [BYTE_W-1:0] CMD_COLUMN_ADDR = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW_ADDR    = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_MEM_WRITE   = 8'h2C;

  typedef enum logic {
    KIND_WINDOW,
    KIND_PIXEL
  } lwpw_kind_t;

  // One classified request waiting for the back end
  typedef struct packed {
    lwpw_kind_t              kind;
    logic [ORIG_W-1:0]       x0;
    logic [ORIG_W-1:0]       y0;
    logic [END_W-1:0]        x1;
    logic [END_W-1:0]        y1;
    logic [PIX_W-1:0]        pixel;
  } lwpw_entry_t;

endpackage

// ===== hdl/lcd_window_pixel_writer.sv =====
// Top level of the window pixel writer: front end, request queue, back end.
//
// Usage: each request on the in_ channel (valid/ready) is either a window
// (in_func 0: origin and size) or one RGB565 pixel (in_func 1). The out_
// channel (valid/ready) carries one byte per cycle while out_ready is high, with its
// data/command flag; out_last marks the final byte of a request.
// A non-empty window yields eleven bytes: column address command 0x2A with
// start and end column, row address command 0x2B with start and end row,
// then memory write 0x2C; it loads the pixel budget with clamped width times height.
// A pixel yields two data bytes, high byte first, while budget remains;
// otherwise it, like an empty window, is dropped with no output.
// The first byte of a request passes through the queue and then the single
// byte-wide output register, which emits one byte per cycle while the
// receiver is ready.
// A two-entry queue decouples request intake from byte emission, so in_ready
// stays high while the queue has room even when the receiver stalls.
// Reset clears the pixel budget, empties the queue and drops out_valid.
module lcd_window_pixel_writer
  import lwpw_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [ORIG_W-1:0] in_x_origin,
  input  logic [ORIG_W-1:0] in_y_origin,
  input  logic [DIM_W-1:0]  in_win_width,
  input  logic [DIM_W-1:0]  in_win_height,
  input  logic [PIX_W-1:0]  in_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_is_data,
  output logic              out_last
);

  logic        q_full;
  logic        q_push;
  lwpw_entry_t q_entry;
  logic        q_pop;
  logic        q_head_valid;
  lwpw_entry_t q_head;

  lwpw_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_x_origin   (in_x_origin),
    .in_y_origin   (in_y_origin),
    .in_win_width  (in_win_width),
    .in_win_height (in_win_height),
    .in_pixel      (in_pixel),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  lwpw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  lwpw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (q_head_valid),
    .head_entry  (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_is_data (out_is_data),
    .out_last    (out_last)
  );

`ifndef SYNTHESIS
  // Command bytes are only ever the three controller commands
  a_cmd_codes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_data) |->
      (out_byte == CMD_COLUMN_ADDR || out_byte == CMD_ROW_ADDR ||
       out_byte == CMD_MEM_WRITE))
    else $error("unexpected command byte");

  // A window ends on the memory write command
  a_win_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_is_data) |-> (out_byte == CMD_MEM_WRITE))
    else $error("window ended on wrong command");

  // Nothing is offered straight after a reset edge
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A full queue stalls intake
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_ready)
    else $error("request taken while queue full");
`endif

endmodule

// ===== hdl/lwpw_front.sv =====
// Front end: accepts requests, clamps the window, tracks the pixel budget.
module lwpw_front
  import lwpw_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [ORIG_W-1:0] in_x_origin,
  input  logic [ORIG_W-1:0] in_y_origin,
  input  logic [DIM_W-1:0]  in_win_width,
  input  logic [DIM_W-1:0]  in_win_height,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              q_full,
  output logic              q_push,
  output lwpw_entry_t       q_entry
);

  logic [LEFT_W-1:0] pixels_left_r;
  logic [LEFT_W-1:0] pixels_left_nxt;
  logic [DIM_W-1:0]  w_cl;
  logic [DIM_W-1:0]  h_cl;
  logic              empty_win;
  logic [PROD_W-1:0] area;
  logic [LEFT_W-1:0] area_sat;
  logic              accept;

  // Clamp the window size to the largest supported dimension
  always_comb begin
    w_cl = in_win_width;
    h_cl = in_win_height;
    if (32'(in_win_width) > MAX_DIM) begin
      w_cl = DIM_W'(MAX_DIM);
    end
    if (32'(in_win_height) > MAX_DIM) begin
      h_cl = DIM_W'(MAX_DIM);
    end
  end

  assign empty_win = (w_cl == '0) || (h_cl == '0);
  assign area      = PROD_W'(w_cl) * PROD_W'(h_cl);
  assign area_sat  = (area > PROD_W'(LEFT_MAX)) ? LEFT_MAX : area[LEFT_W-1:0];

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify: drop empty windows and pixels with no budget left
  always_comb begin
    q_push          = 1'b0;
    pixels_left_nxt = pixels_left_r;
    if (accept) begin
      if (in_func == 1'b0) begin
        if (!empty_win) begin
          q_push          = 1'b1;
          pixels_left_nxt = area_sat;
        end
      end else if (pixels_left_r != '0) begin
        q_push          = 1'b1;
        pixels_left_nxt = pixels_left_r - 1'b1;
      end
    end
  end

  // Build the queue entry, end coordinates included
  always_comb begin
    q_entry.kind  = in_func ? KIND_PIXEL : KIND_WINDOW;
    q_entry.x0    = in_x_origin;
    q_entry.y0    = in_y_origin;
    q_entry.x1    = END_W'(in_x_origin) + END_W'(w_cl) - 1'b1;
    q_entry.y1    = END_W'(in_y_origin) + END_W'(h_cl) - 1'b1;
    q_entry.pixel = in_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r <= '0;
    end else begin
      pixels_left_r <= pixels_left_nxt;
    end
  end

endmodule

// ===== hdl/lwpw_queue.sv =====
// Short request queue between front and back end.
module lwpw_queue
  import lwpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lwpw_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output lwpw_entry_t head_entry
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  lwpw_entry_t       slot_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == CNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store the request payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lwpw_back.sv =====
// Back end: walks each queued request byte by byte into the output register.
module lwpw_back
  import lwpw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  lwpw_entry_t       head_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_is_data,
  output logic              out_last
);

  localparam logic [3:0] IDX_COL_CMD = 4'd0;
  localparam logic [3:0] IDX_XS_HI   = 4'd1;
  localparam logic [3:0] IDX_XS_LO   = 4'd2;
  localparam logic [3:0] IDX_XE_HI   = 4'd3;
  localparam logic [3:0] IDX_XE_LO   = 4'd4;
  localparam logic [3:0] IDX_ROW_CMD = 4'd5;
  localparam logic [3:0] IDX_YS_HI   = 4'd6;
  localparam logic [3:0] IDX_YS_LO   = 4'd7;
  localparam logic [3:0] IDX_YE_HI   = 4'd8;
  localparam logic [3:0] IDX_YE_LO   = 4'd9;

  logic [3:0]        idx_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_is_data_r;
  logic              out_last_r;
  logic              load;
  logic [BYTE_W-1:0] sel_byte;
  logic              sel_data;
  logic              sel_fin;

  assign load = !out_valid_r || out_ready;
  assign pop  = load && head_valid && sel_fin;

  // Pick the byte at the current position of the head request
  always_comb begin
    sel_byte = '0;
    sel_data = 1'b1;
    sel_fin  = 1'b0;
    if (head_entry.kind == KIND_PIXEL) begin
      if (idx_r == IDX_COL_CMD) begin
        sel_byte = head_entry.pixel[PIX_W-1:BYTE_W];
      end else begin
        sel_byte = head_entry.pixel[BYTE_W-1:0];
        sel_fin  = 1'b1;
      end
    end else begin
      unique case (idx_r)
        IDX_COL_CMD: begin
          sel_byte = CMD_COLUMN_ADDR;
          sel_data = 1'b0;
        end
        IDX_XS_HI: sel_byte = BYTE_W'(head_entry.x0[ORIG_W-1:BYTE_W]);
        IDX_XS_LO: sel_byte = head_entry.x0[BYTE_W-1:0];
        IDX_XE_HI: sel_byte = BYTE_W'(head_entry.x1[END_W-1:BYTE_W]);
        IDX_XE_LO: sel_byte = head_entry.x1[BYTE_W-1:0];
        IDX_ROW_CMD: begin
          sel_byte = CMD_ROW_ADDR;
          sel_data = 1'b0;
        end
        IDX_YS_HI: sel_byte = BYTE_W'(head_entry.y0[ORIG_W-1:BYTE_W]);
        IDX_YS_LO: sel_byte = head_entry.y0[BYTE_W-1:0];
        IDX_YE_HI: sel_byte = BYTE_W'(head_entry.y1[END_W-1:BYTE_W]);
        IDX_YE_LO: sel_byte = head_entry.y1[BYTE_W-1:0];
        default: begin
          sel_byte = CMD_MEM_WRITE;
          sel_data = 1'b0;
          sel_fin  = 1'b1;
        end
      endcase
    end
  end

  // Advance position and fill the output register when it frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= IDX_COL_CMD;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        idx_r <= sel_fin ? IDX_COL_CMD : idx_r + 1'b1;
      end
    end
  end

  // Hold the payload until taken
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte_r    <= sel_byte;
      out_is_data_r <= sel_data;
      out_last_r    <= sel_fin;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_data = out_is_data_r;
  assign out_last    = out_last_r;

endmodule
